/* src/lcp_pkg.sv */
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared constants and types of the line command parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

   // Line buffer capacity: only the first LineCapacity-1 bytes of a line count.
   localparam int LineCapacity = 20;
   localparam int PosWidth     = $clog2(LineCapacity);
   localparam logic [PosWidth-1:0] PosLimit = PosWidth'(LineCapacity - 1);
   localparam logic [PosWidth-1:0] MinLength = PosWidth'(3);

   localparam int ArgWidth = 32;
   localparam int CodeWidth = 3;
   localparam int SumWidth = ArgWidth + 4;

   // Byte codes
   localparam logic [7:0] CharNul   = 8'd0;
   localparam logic [7:0] CharTab   = 8'd9;
   localparam logic [7:0] CharLf    = 8'd10;
   localparam logic [7:0] CharCr    = 8'd13;
   localparam logic [7:0] CharSpace = 8'd32;
   localparam logic [7:0] CharPlus  = 8'd43;
   localparam logic [7:0] CharMinus = 8'd45;
   localparam logic [7:0] CharZero  = 8'd48;
   localparam logic [7:0] CharOne   = 8'd49;
   localparam logic [7:0] CharNine  = 8'd57;

   // Command codes
   localparam logic [CodeWidth-1:0] CmdForward  = 3'd0;
   localparam logic [CodeWidth-1:0] CmdBackward = 3'd1;
   localparam logic [CodeWidth-1:0] CmdRotate   = 3'd2;
   localparam logic [CodeWidth-1:0] CmdScan     = 3'd3;
   localparam logic [CodeWidth-1:0] CmdUnknown  = 3'd4;

   // Magnitude cap: 2^31
   localparam logic [SumWidth-1:0] MagLimit = SumWidth'(36'h0_8000_0000);
   localparam logic [ArgWidth-1:0] ArgMax   = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      PHASE_SKIP   = 3'b001,
      PHASE_DIGITS = 3'b010,
      PHASE_DONE   = 3'b100
   } phase_type;

endpackage

/* src/line_command_parser_core.sv */
// ----------------------------------------------------------------------------
// line_command_parser_core
// Assembles serial bytes into a command line and, on CR or LF, emits the
// decoded two-character command code and its signed decimal argument.
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid, req_ready, req_rx_byte              | in
//  rsp     | rsp_valid, rsp_ready, rsp_command_code,        | out
//          | rsp_argument, rsp_too_short                    |
//
//  One byte per cycle. Each byte updates the line state in the cycle it is
//  accepted (one multiply-by-ten-and-add on the accumulator); a CR or LF
//  loads the result register and the item is visible on rsp the next cycle.
//  Synchronous reset clears the line state and the result valid.
//  req_ready drops only while a result is held and rsp_ready is low.
//
module line_command_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lcp_pkg::CodeWidth-1:0]      rsp_command_code,
   output logic signed [lcp_pkg::ArgWidth-1:0] rsp_argument,
   output logic                               rsp_too_short
);

   logic [lcp_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]                   first_ff, first_in;
   logic [7:0]                   second_ff, second_in;
   lcp_pkg::phase_type           phase_ff, phase_in;
   logic                         neg_ff, neg_in;
   logic [lcp_pkg::ArgWidth-1:0] acc_ff, acc_in;
   logic                         ended_ff, ended_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lcp_pkg::CodeWidth-1:0] code_ff, code_in;
   logic [lcp_pkg::ArgWidth-1:0] arg_ff, arg_in;
   logic                         short_ff, short_in;

   logic                         accept;
   logic                         is_eol;
   logic                         is_digit;
   logic                         is_space;
   logic [3:0]                   digit_raw;
   logic [lcp_pkg::SumWidth-1:0] acc_wide;
   logic [lcp_pkg::SumWidth-1:0] acc_sum;
   logic [lcp_pkg::ArgWidth-1:0] acc_digit;
   logic [lcp_pkg::CodeWidth-1:0] code_dec;
   logic [lcp_pkg::ArgWidth-1:0] arg_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_eol   = (req_rx_byte == lcp_pkg::CharCr) || (req_rx_byte == lcp_pkg::CharLf);
   assign is_digit = (req_rx_byte >= lcp_pkg::CharZero) && (req_rx_byte <= lcp_pkg::CharNine);
   assign is_space = (req_rx_byte == lcp_pkg::CharSpace) ||
                     ((req_rx_byte >= lcp_pkg::CharTab) && (req_rx_byte <= lcp_pkg::CharCr));

   // acc * 10 + digit, capped at 2^31; ASCII digits hold their value in the low nibble
   assign digit_raw = req_rx_byte[3:0];
   assign acc_wide  = {4'b0, acc_ff};
   assign acc_sum   = (acc_wide << 3) + (acc_wide << 1) +
                      {{(lcp_pkg::SumWidth-4){1'b0}}, digit_raw};
   assign acc_digit = (acc_sum > lcp_pkg::MagLimit) ? lcp_pkg::MagLimit[lcp_pkg::ArgWidth-1:0]
                                                    : acc_sum[lcp_pkg::ArgWidth-1:0];

   always_comb begin
      priority if (first_ff == lcp_pkg::CharZero && second_ff == lcp_pkg::CharZero) begin
         code_dec = lcp_pkg::CmdForward;
      end else if (first_ff == lcp_pkg::CharZero && second_ff == lcp_pkg::CharOne) begin
         code_dec = lcp_pkg::CmdBackward;
      end else if (first_ff == lcp_pkg::CharOne && second_ff == lcp_pkg::CharZero) begin
         code_dec = lcp_pkg::CmdRotate;
      end else if (first_ff == lcp_pkg::CharOne && second_ff == lcp_pkg::CharOne) begin
         code_dec = lcp_pkg::CmdScan;
      end else begin
         code_dec = lcp_pkg::CmdUnknown;
      end
   end

   // acc_ff[31] is set only at the cap, which saturates the positive side
   assign arg_dec = neg_ff ? (32'd0 - acc_ff) : (acc_ff[31] ? lcp_pkg::ArgMax : acc_ff);

   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      second_in = second_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      ended_in  = ended_ff;
      code_in   = code_ff;
      arg_in    = arg_ff;
      short_in  = short_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         if (is_eol) begin
            rsp_valid_in = 1'b1;
            if (pos_ff < lcp_pkg::MinLength) begin
               code_in  = lcp_pkg::CmdForward;
               arg_in   = '0;
               short_in = 1'b1;
            end else begin
               code_in  = code_dec;
               arg_in   = arg_dec;
               short_in = 1'b0;
            end
            pos_in    = '0;
            first_in  = '0;
            second_in = '0;
            phase_in  = lcp_pkg::PHASE_SKIP;
            neg_in    = 1'b0;
            acc_in    = '0;
            ended_in  = 1'b0;
         end else if (!ended_ff && (pos_ff < lcp_pkg::PosLimit)) begin
            if (req_rx_byte == lcp_pkg::CharNul) begin
               ended_in = 1'b1;
            end else begin
               pos_in = pos_ff + lcp_pkg::PosWidth'(1);
               if (pos_ff == '0) begin
                  first_in = req_rx_byte;
               end else if (pos_ff == lcp_pkg::PosWidth'(1)) begin
                  second_in = req_rx_byte;
               end else begin
                  unique case (phase_ff)
                     lcp_pkg::PHASE_SKIP: begin
                        if (!is_space) begin
                           if (req_rx_byte == lcp_pkg::CharPlus ||
                               req_rx_byte == lcp_pkg::CharMinus) begin
                              neg_in   = (req_rx_byte == lcp_pkg::CharMinus);
                              phase_in = lcp_pkg::PHASE_DIGITS;
                           end else if (is_digit) begin
                              acc_in   = acc_digit;
                              phase_in = lcp_pkg::PHASE_DIGITS;
                           end else begin
                              phase_in = lcp_pkg::PHASE_DONE;
                           end
                        end
                     end
                     lcp_pkg::PHASE_DIGITS: begin
                        if (is_digit) begin
                           acc_in = acc_digit;
                        end else begin
                           phase_in = lcp_pkg::PHASE_DONE;
                        end
                     end
                     lcp_pkg::PHASE_DONE: begin
                     end
                     default: begin
                        phase_in = lcp_pkg::PHASE_DONE;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         phase_ff     <= lcp_pkg::PHASE_SKIP;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      arg_ff   <= arg_in;
      short_ff <= short_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = code_ff;
   assign rsp_argument     = arg_ff;
   assign rsp_too_short    = short_ff;

   // A line end always produces an item on the next cycle
   a_eol_result: assert property (@(posedge clock) disable iff (reset)
      (accept && is_eol) |=> rsp_valid_ff)
      else $error("line end did not load a result");

   // Short lines carry zero code and argument
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && short_ff) |-> (code_ff == lcp_pkg::CmdForward && arg_ff == '0))
      else $error("short line with nonzero fields");

   // Kept characters never exceed the line capacity
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= lcp_pkg::PosLimit)
      else $error("position past line capacity");

   // Magnitude never exceeds 2^31
   a_acc_cap: assert property (@(posedge clock) disable iff (reset)
      acc_ff[31] |-> (acc_ff[30:0] == '0))
      else $error("accumulator above cap");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_command_parser_core. Bytes of well-formed,
// short, overlong and garbled command lines are pushed through the req
// channel under three pacing mixes. A line predictor works out the result
// of every CR or LF, and each rsp item is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [7:0] CharVtab     = 8'd11;
   localparam logic [7:0] CharFormFeed = 8'd12;
   localparam int SendIdlePct[3] = '{37, 85, 0};
   localparam int RecvIdlePct[3] = '{85, 37, 0};
   localparam int PhaseBytes  = 410;
   localparam int StallLimit  = 4000;
   localparam int DrainCycles = 20;

   typedef struct {
      logic [lcp_pkg::CodeWidth-1:0]       code;
      logic signed [lcp_pkg::ArgWidth-1:0] arg;
      logic                                too_short;
   } line_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [lcp_pkg::CodeWidth-1:0] rsp_command_code;
   logic signed [lcp_pkg::ArgWidth-1:0] rsp_argument;
   logic rsp_too_short;

   logic [7:0]      pending_bytes[$];
   line_result_type expected_results[$];
   line_result_type got_line;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int lines_checked = 0;
   int short_lines = 0;
   int saturated_lines = 0;
   int stall_cycles = 0;

   // line state of the predictor
   int                 line_len;
   logic [7:0]         cmd_first;
   logic [7:0]         cmd_second;
   lcp_pkg::phase_type num_phase;
   logic               is_negative;
   logic [31:0]        magnitude;
   logic               line_cut;

   string limit_numbers[5] = '{"2147483647", "2147483648", "2147483649",
                               "4294967295", "9999999999"};

   line_command_parser_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_code (rsp_command_code),
      .rsp_argument     (rsp_argument),
      .rsp_too_short    (rsp_too_short)
   );

   always #10 clock = ~clock;

   function automatic void clear_line();
      line_len    = 0;
      cmd_first   = 8'd0;
      cmd_second  = 8'd0;
      num_phase   = lcp_pkg::PHASE_SKIP;
      is_negative = 1'b0;
      magnitude   = 32'd0;
      line_cut    = 1'b0;
   endfunction

   function automatic void parse_byte(input logic [7:0] c);
      line_result_type r;
      logic [35:0] wide;
      logic is_digit;
      is_digit = (c >= lcp_pkg::CharZero) && (c <= lcp_pkg::CharNine);
      if (c == lcp_pkg::CharCr || c == lcp_pkg::CharLf) begin
         r.code = lcp_pkg::CmdForward;
         r.arg = '0;
         r.too_short = 1'b0;
         if (line_len < int'(lcp_pkg::MinLength)) begin
            r.too_short = 1'b1;
         end else begin
            case ({cmd_first, cmd_second})
               {lcp_pkg::CharZero, lcp_pkg::CharZero}: r.code = lcp_pkg::CmdForward;
               {lcp_pkg::CharZero, lcp_pkg::CharOne}:  r.code = lcp_pkg::CmdBackward;
               {lcp_pkg::CharOne, lcp_pkg::CharZero}:  r.code = lcp_pkg::CmdRotate;
               {lcp_pkg::CharOne, lcp_pkg::CharOne}:   r.code = lcp_pkg::CmdScan;
               default:                                r.code = lcp_pkg::CmdUnknown;
            endcase
            if (is_negative) r.arg = 32'd0 - magnitude;
            else r.arg = (magnitude > lcp_pkg::ArgMax) ? lcp_pkg::ArgMax : magnitude;
         end
         expected_results.push_back(r);
         clear_line();
      end else if (!line_cut && line_len < lcp_pkg::LineCapacity - 1) begin
         if (c == lcp_pkg::CharNul) begin
            line_cut = 1'b1;
         end else begin
            if (line_len == 0) begin
               cmd_first = c;
            end else if (line_len == 1) begin
               cmd_second = c;
            end else if (num_phase == lcp_pkg::PHASE_SKIP) begin
               if (c == lcp_pkg::CharPlus || c == lcp_pkg::CharMinus) begin
                  is_negative = (c == lcp_pkg::CharMinus);
                  num_phase = lcp_pkg::PHASE_DIGITS;
               end else if (is_digit) begin
                  magnitude = 32'(c - lcp_pkg::CharZero);
                  num_phase = lcp_pkg::PHASE_DIGITS;
               end else if (!(c == lcp_pkg::CharSpace || c == lcp_pkg::CharTab ||
                              c == CharVtab || c == CharFormFeed)) begin
                  num_phase = lcp_pkg::PHASE_DONE;
               end
            end else if (num_phase == lcp_pkg::PHASE_DIGITS) begin
               if (is_digit) begin
                  // magnitude saturates at 2^31
                  wide = 36'(magnitude) * 36'd10 + 36'(c - lcp_pkg::CharZero);
                  magnitude = (wide > 36'h0_8000_0000) ? 32'h8000_0000 : wide[31:0];
               end else begin
                  num_phase = lcp_pkg::PHASE_DONE;
               end
            end
            line_len++;
         end
      end
   endfunction

   function automatic logic [7:0] random_text_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == lcp_pkg::CharCr || c == lcp_pkg::CharLf);
      return c;
   endfunction

   function automatic void push_text(input string s);
      foreach (s[i]) pending_bytes.push_back(8'(s[i]));
   endfunction

   // one line of random content, ended by CR or LF
   function automatic void add_line();
      int unsigned kind;
      logic [7:0] blanks[4] = '{lcp_pkg::CharSpace, lcp_pkg::CharTab, CharVtab, CharFormFeed};
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(2)) pending_bytes.push_back(random_text_byte());
      end else if (kind < 22) begin
         repeat ($urandom_range(1, 30)) pending_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat (2) begin
            if ($urandom_range(3) != 0)
               pending_bytes.push_back(lcp_pkg::CharZero + 8'($urandom_range(1)));
            else
               pending_bytes.push_back(random_text_byte());
         end
         repeat ($urandom_range(3)) pending_bytes.push_back(blanks[$urandom_range(3)]);
         case ($urandom_range(2))
            1: pending_bytes.push_back(lcp_pkg::CharPlus);
            2: pending_bytes.push_back(lcp_pkg::CharMinus);
            default: ;
         endcase
         case ($urandom_range(9))
            0: push_text(limit_numbers[$urandom_range(4)]);
            1: repeat ($urandom_range(11, 22))
                  pending_bytes.push_back(lcp_pkg::CharZero + 8'($urandom_range(9)));
            default: repeat ($urandom_range(6))
                  pending_bytes.push_back(lcp_pkg::CharZero + 8'($urandom_range(9)));
         endcase
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 8)) pending_bytes.push_back(random_text_byte());
      end
      pending_bytes.push_back($urandom_range(1) ? lcp_pkg::CharCr : lcp_pkg::CharLf);
   endfunction

   // driver: predicts at acceptance, then offers the next byte
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result code %0d arg %0d short %0b", $time,
                        rsp_command_code, rsp_argument, rsp_too_short);
               error_count++;
            end else begin
               got_line = expected_results.pop_front();
               if (rsp_command_code !== got_line.code) begin
                  $display("%0t: command_code expected %0d actual %0d", $time,
                           got_line.code, rsp_command_code);
                  error_count++;
               end
               if (rsp_argument !== got_line.arg) begin
                  $display("%0t: argument expected %0d actual %0d", $time,
                           got_line.arg, rsp_argument);
                  error_count++;
               end
               if (rsp_too_short !== got_line.too_short) begin
                  $display("%0t: too_short expected %0b actual %0b", $time,
                           got_line.too_short, rsp_too_short);
                  error_count++;
               end
               lines_checked++;
               if (got_line.too_short) short_lines++;
               if (!got_line.too_short && (got_line.arg == lcp_pkg::ArgMax ||
                   got_line.arg == $signed(32'h8000_0000)))
                  saturated_lines++;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles == StallLimit) begin
            $display("%0t: no handshake for %0d cycles", $time, StallLimit);
            $display("line_command_parser_core regression: fail");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      clear_line();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SendIdlePct[phase];
         recv_idle_pct = RecvIdlePct[phase];
         if (phase == 0) begin
            push_text("\r");                // empty line
            push_text("00-\r");             // sign with no digits
            push_text("01-7\n");
            push_text("10 5");              // zero byte cuts the line
            pending_bytes.push_back(lcp_pkg::CharNul);
            push_text(" 9\n");
            pending_bytes.push_back(8'hFF);
            push_text("1 3\r");
            push_text("11\v9\n");
         end
         while (pending_bytes.size() < PhaseBytes) add_line();
         do @(negedge clock); while (pending_bytes.size() != 0 || req_valid);
         // hold the sender until every result of this phase is back
         do @(negedge clock); while (expected_results.size() != 0);
      end
      repeat (DrainCycles) @(negedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         error_count++;
      end
      $display("Sent %0d bytes; checked %0d result lines, %0d too short, %0d saturated,",
               bytes_sent, lines_checked, short_lines, saturated_lines);
      $display("under sender-heavy, receiver-heavy and back-to-back pacing.");
      if (error_count == 0) begin
         $display("line_command_parser_core regression: pass");
      end else begin
         $display("line_command_parser_core regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
src/lcp_pkg.sv
src/line_command_parser_core.sv
test/testbench.sv
